// ----- hdl/bfshp_pkg.sv -----
// Package for the shortest Hamiltonian path search core.
// Holds sizes, types, the sequencer states and small helper functions.
// No dependencies; every other file of the block uses it.
package bfshp_pkg;

    // Sizing of the weight store and the chain of position cells.
    localparam int MAX_VERTICES = 12;
    localparam int MIN_VERTICES = 3;
    localparam int WEIGHT_BITS  = 8;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int MEM_DEPTH    = MAX_VERTICES * MAX_VERTICES;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);
    localparam int SUM_W        = WEIGHT_BITS + VIDX_W;

    // Fixed widths of the transaction fields.
    localparam int VFIELD_W = 4;
    localparam int WFIELD_W = 8;
    localparam int DIST_W   = 12;
    localparam int DIST_MAX = 4095;
    localparam int WIDE_W   = (SUM_W > DIST_W) ? SUM_W : DIST_W;

    // Configuration port.
    localparam int APB_AW           = 3;
    localparam int APB_DW           = 32;
    localparam bit REG_VERTEX_COUNT = 1'b0;
    localparam int VCOUNT_RESET     = 12;

    // Commands carried by the input transaction.
    localparam logic CMD_WRITE_EDGE = 1'b0;
    localparam logic CMD_SEARCH     = 1'b1;

    typedef logic [VIDX_W-1:0]   t_vidx;
    typedef logic [VIDX_W:0]     t_cnt;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [WIDE_W-1:0]   t_wide;
    typedef logic [DIST_W-1:0]   t_dist;
    typedef logic [MEM_AW-1:0]   t_addr;
    typedef logic [VFIELD_W-1:0] t_vfield;
    typedef logic [WFIELD_W-1:0] t_wfield;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_RD,
        ST_INIT_ACC,
        ST_SWAP,
        ST_UPD,
        ST_OUT
    } t_state;

    // Broadcast control from the sequencer to every position cell.
    typedef struct packed {
        t_cnt    n;
        logic    init;
        logic    swap;
        t_vidx   lo;
        t_vidx   mval;
        logic    capture;
        logic    la_we;
        t_vidx   la_pos;
        t_weight la_data;
        logic    lb_we;
        t_vidx   lb_pos;
        t_weight lb_data;
    } t_cell_ctl;

    // What each cell shows to its neighbors and to the sequencer.
    typedef struct packed {
        t_vidx   val;
        logic    dir;
        t_weight link;
        t_vidx   best;
        logic    mobile;
    } t_cell_stat;

    // Address of an unordered vertex pair; only one triangle is stored.
    function automatic t_addr edge_addr(t_vidx p, t_vidx q);
        t_vidx lo_v;
        t_vidx hi_v;
        lo_v = (p < q) ? p : q;
        hi_v = (p < q) ? q : p;
        return t_addr'(t_addr'(lo_v) * t_addr'(MAX_VERTICES) + t_addr'(hi_v));
    endfunction

    // Saturate a path sum to the width of the distance field.
    function automatic t_dist sat_dist(t_sum s);
        t_wide w;
        w = t_wide'(s);
        return (w > t_wide'(DIST_MAX)) ? t_dist'(DIST_MAX) : t_dist'(w);
    endfunction

endpackage

// ----- hdl/bfshp_if.sv -----
// Valid/ready channel interfaces of the shortest Hamiltonian path core.
// Depends on bfshp_pkg for the field types.

// Command channel: edge writes and search requests.
interface bfshp_cmd_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    bfshp_pkg::t_vfield    vertex_a;
    bfshp_pkg::t_vfield    vertex_b;
    bfshp_pkg::t_wfield    weight;

    modport source(output valid, output cmd, output vertex_a, output vertex_b,
                   output weight, input ready);
    modport sink(input valid, input cmd, input vertex_a, input vertex_b,
                 input weight, output ready);
endinterface

// Result channel: one transaction per vertex of the best path.
interface bfshp_res_if;
    logic               valid;
    logic               ready;
    bfshp_pkg::t_vfield position;
    bfshp_pkg::t_vfield vertex;
    bfshp_pkg::t_dist   total_distance;
    logic               last;

    modport source(output valid, output position, output vertex,
                   output total_distance, output last, input ready);
    modport sink(input valid, input position, input vertex,
                 input total_distance, input last, output ready);
endinterface

// ----- hdl/bfshp_cell.sv -----
// One position cell of the permutation chain: vertex, direction, link weight.
// Trades contents with its neighbors on an adjacent swap. Uses bfshp_pkg.
module bfshp_cell (
    input  logic                  i_clk,
    input  bfshp_pkg::t_vidx      i_idx,
    input  bfshp_pkg::t_cell_ctl  i_ctl,
    input  bfshp_pkg::t_cell_stat i_left,
    input  bfshp_pkg::t_cell_stat i_right,
    output bfshp_pkg::t_cell_stat o_stat
);

    bfshp_pkg::t_vidx   r_val;
    bfshp_pkg::t_vidx   n_val;
    logic               r_dir;
    logic               n_dir;
    bfshp_pkg::t_weight r_link;
    bfshp_pkg::t_weight n_link;
    bfshp_pkg::t_vidx   r_best;
    bfshp_pkg::t_vidx   n_best;
    bfshp_pkg::t_cnt    w_idx_c;
    bfshp_pkg::t_cnt    w_lo_c;
    logic               w_left_ok;
    logic               w_right_ok;
    logic               w_mobile;

    // Mobility: the element points at a smaller neighbor inside positions 1..n-1.
    always_comb begin
        w_idx_c    = bfshp_pkg::t_cnt'(i_idx);
        w_lo_c     = bfshp_pkg::t_cnt'(i_ctl.lo);
        w_left_ok  = !r_dir && (w_idx_c >= bfshp_pkg::t_cnt'(2)) && (r_val > i_left.val);
        w_right_ok = r_dir && ((w_idx_c + bfshp_pkg::t_cnt'(1)) < i_ctl.n)
                     && (r_val > i_right.val);
        w_mobile   = (w_idx_c >= bfshp_pkg::t_cnt'(1)) && (w_idx_c < i_ctl.n)
                     && (w_left_ok || w_right_ok);
    end

    // Next contents: reset to identity, adjacent swap with direction flips, link updates, best capture.
    always_comb begin
        n_val  = r_val;
        n_dir  = r_dir;
        n_link = r_link;
        n_best = r_best;
        if (i_ctl.init) begin
            n_val = i_idx;
            n_dir = 1'b0;
        end else if (i_ctl.swap) begin
            if (i_idx == i_ctl.lo) begin
                n_val = i_right.val;
                n_dir = i_right.dir;
            end else if (w_idx_c == w_lo_c + bfshp_pkg::t_cnt'(1)) begin
                n_val = i_left.val;
                n_dir = i_left.dir;
            end
            n_dir = n_dir ^ (n_val > i_ctl.mval);
        end
        if (i_ctl.la_we && (i_idx == i_ctl.la_pos)) begin
            n_link = i_ctl.la_data;
        end else if (i_ctl.lb_we && (i_idx == i_ctl.lb_pos)) begin
            n_link = i_ctl.lb_data;
        end
        if (i_ctl.capture) begin
            n_best = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_dir  <= n_dir;
        r_link <= n_link;
        r_best <= n_best;
    end

    assign o_stat.val    = r_val;
    assign o_stat.dir    = r_dir;
    assign o_stat.link   = r_link;
    assign o_stat.best   = r_best;
    assign o_stat.mobile = w_mobile;

endmodule

// ----- hdl/bfshp_wmem.sv -----
// Edge weight store: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero. Uses bfshp_pkg.
module bfshp_wmem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  bfshp_pkg::t_addr   i_waddr,
    input  bfshp_pkg::t_weight i_wdata,
    input  bfshp_pkg::t_addr   i_raddr_a,
    input  bfshp_pkg::t_addr   i_raddr_b,
    output bfshp_pkg::t_weight o_rdata_a,
    output bfshp_pkg::t_weight o_rdata_b
);

    bfshp_pkg::t_weight r_mem [bfshp_pkg::MEM_DEPTH];
    logic               r_valid [bfshp_pkg::MEM_DEPTH];
    bfshp_pkg::t_weight r_rd_a;
    bfshp_pkg::t_weight r_rd_b;
    logic               r_ok_a;
    logic               r_ok_b;

    // Storage array, no reset.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    // Valid bits are cleared by reset so the store reads as all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bfshp_pkg::MEM_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_ok_a <= 1'b0;
            r_ok_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_ok_a <= r_valid[i_raddr_a];
            r_ok_b <= r_valid[i_raddr_b];
        end
    end

    assign o_rdata_a = r_ok_a ? r_rd_a : '0;
    assign o_rdata_b = r_ok_b ? r_rd_b : '0;

endmodule

// ----- hdl/brute_force_shortest_hamiltonian_path_core.sv -----
// Shortest Hamiltonian path search core: chain of position cells and a sequencer.
// Search of n vertices: load the path of the identity order link by link, then visit
// (n-1)! orders, each with one swap and one weight-store read pair, then give
// n results at one per cycle while the result channel is ready.
// One search at a time. Reset is synchronous: weight store reads zero, vertex_count 12.
// Depends on bfshp_pkg, bfshp_if, bfshp_cell and bfshp_wmem.
module brute_force_shortest_hamiltonian_path_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bfshp_cmd_if.sink                       i_cmd,
    bfshp_res_if.source                     o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfshp_pkg::APB_AW-1:0]    paddr,
    input  logic [bfshp_pkg::APB_DW-1:0]    pwdata,
    output logic [bfshp_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);

    // Control and datapath registers.
    bfshp_pkg::t_state  r_state;
    bfshp_pkg::t_state  n_state;
    bfshp_pkg::t_vfield r_vcount;
    bfshp_pkg::t_cnt    r_n;
    bfshp_pkg::t_cnt    n_n;
    bfshp_pkg::t_vidx   r_k;
    bfshp_pkg::t_vidx   n_k;
    bfshp_pkg::t_sum    r_d;
    bfshp_pkg::t_sum    n_d;
    bfshp_pkg::t_sum    r_best_d;
    bfshp_pkg::t_sum    n_best_d;
    logic               r_found;
    logic               n_found;
    bfshp_pkg::t_vidx   r_mval;
    bfshp_pkg::t_vidx   n_mval;
    bfshp_pkg::t_vidx   r_lo;
    bfshp_pkg::t_vidx   n_lo;
    bfshp_pkg::t_sum    r_sub;
    bfshp_pkg::t_sum    n_sub;
    logic               r_has_b;
    logic               n_has_b;
    logic               r_out_valid;
    logic               n_out_valid;
    bfshp_pkg::t_vfield r_out_pos;
    bfshp_pkg::t_vfield n_out_pos;
    bfshp_pkg::t_vfield r_out_vtx;
    bfshp_pkg::t_vfield n_out_vtx;
    bfshp_pkg::t_dist   r_out_dist;
    bfshp_pkg::t_dist   n_out_dist;
    logic               r_out_last;
    logic               n_out_last;

    // Cell chain and weight store signals.
    bfshp_pkg::t_cell_ctl  w_ctl;
    bfshp_pkg::t_cell_stat w_stat [bfshp_pkg::MAX_VERTICES];
    logic                  w_we;
    bfshp_pkg::t_addr      w_waddr;
    bfshp_pkg::t_weight    w_wdata;
    bfshp_pkg::t_addr      w_raddr_a;
    bfshp_pkg::t_addr      w_raddr_b;
    bfshp_pkg::t_weight    w_rdata_a;
    bfshp_pkg::t_weight    w_rdata_b;

    // Selection and swap helpers.
    logic [bfshp_pkg::MAX_VERTICES-1:0] w_mob_by_val;
    logic               w_found;
    bfshp_pkg::t_vidx   w_mval;
    bfshp_pkg::t_vidx   w_mpos;
    logic               w_mdir;
    bfshp_pkg::t_vidx   w_lo;
    bfshp_pkg::t_cnt    w_lo2_c;
    logic               w_has_b;
    bfshp_pkg::t_vidx   w_lo2;
    bfshp_pkg::t_cnt    w_vc_c;
    bfshp_pkg::t_cnt    w_n_clamped;
    bfshp_pkg::t_sum    w_d_new;
    bfshp_pkg::t_sum    w_d_init;
    logic               w_cmd_fire;
    logic               w_res_fire;
    logic               w_edge_ok;
    logic               w_apb_wr;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_apb_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == bfshp_pkg::REG_VERTEX_COUNT)
                      ? bfshp_pkg::APB_DW'(r_vcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= bfshp_pkg::t_vfield'(bfshp_pkg::VCOUNT_RESET);
        end else if (w_apb_wr && (paddr[2] == bfshp_pkg::REG_VERTEX_COUNT)) begin
            r_vcount <= pwdata[bfshp_pkg::VFIELD_W-1:0];
        end
    end

    // Weight store.
    bfshp_wmem u_wmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Chain of position cells; the ends see an empty neighbor.
    for (genvar g = 0; g < bfshp_pkg::MAX_VERTICES; g++) begin : g_cell
        bfshp_pkg::t_cell_stat w_left;
        bfshp_pkg::t_cell_stat w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_stat[g-1];
        end
        if (g == bfshp_pkg::MAX_VERTICES - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_stat[g+1];
        end
        bfshp_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (bfshp_pkg::t_vidx'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_stat  (w_stat[g])
        );
    end

    // Largest mobile element: flag each value that is mobile, take the highest.
    always_comb begin
        for (int v = 0; v < bfshp_pkg::MAX_VERTICES; v++) begin
            w_mob_by_val[v] = 1'b0;
            for (int i = 0; i < bfshp_pkg::MAX_VERTICES; i++) begin
                if (w_stat[i].mobile && (w_stat[i].val == bfshp_pkg::t_vidx'(v))) begin
                    w_mob_by_val[v] = 1'b1;
                end
            end
        end
        w_found = |w_mob_by_val;
        w_mval  = '0;
        for (int v = 0; v < bfshp_pkg::MAX_VERTICES; v++) begin
            if (w_mob_by_val[v]) begin
                w_mval = bfshp_pkg::t_vidx'(v);
            end
        end
        w_mpos = '0;
        w_mdir = 1'b0;
        for (int i = 0; i < bfshp_pkg::MAX_VERTICES; i++) begin
            if (w_stat[i].mobile && (w_stat[i].val == w_mval)) begin
                w_mpos = bfshp_pkg::t_vidx'(i);
                w_mdir = w_stat[i].dir;
            end
        end
        w_lo = w_mdir ? w_mpos : w_mpos - bfshp_pkg::t_vidx'(1);
    end

    // Position after the swapped pair, and whether it is still on the path.
    assign w_lo2_c = bfshp_pkg::t_cnt'(r_lo) + bfshp_pkg::t_cnt'(2);
    assign w_has_b = (w_lo2_c < r_n);
    assign w_lo2   = w_has_b ? w_lo2_c[bfshp_pkg::VIDX_W-1:0] : r_lo;

    // Clamp the configured vertex count to the supported range.
    assign w_vc_c      = bfshp_pkg::t_cnt'(r_vcount);
    assign w_n_clamped = (w_vc_c < bfshp_pkg::t_cnt'(bfshp_pkg::MIN_VERTICES))
                         ? bfshp_pkg::t_cnt'(bfshp_pkg::MIN_VERTICES)
                         : (w_vc_c > bfshp_pkg::t_cnt'(bfshp_pkg::MAX_VERTICES))
                           ? bfshp_pkg::t_cnt'(bfshp_pkg::MAX_VERTICES) : w_vc_c;

    // Path sum after a swap: up to two links leave, as many new links come from the store.
    assign w_d_new  = r_d + bfshp_pkg::t_sum'(w_rdata_a)
                      + (r_has_b ? bfshp_pkg::t_sum'(w_rdata_b) : '0) - r_sub;
    assign w_d_init = r_d + bfshp_pkg::t_sum'(w_rdata_a);

    assign w_cmd_fire = i_cmd.valid && i_cmd.ready;
    assign w_res_fire = o_res.valid && o_res.ready;
    assign w_edge_ok  = (i_cmd.vertex_a < bfshp_pkg::t_vfield'(bfshp_pkg::MAX_VERTICES))
                        && (i_cmd.vertex_b < bfshp_pkg::t_vfield'(bfshp_pkg::MAX_VERTICES));

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfshp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_k        <= n_k;
        r_d        <= n_d;
        r_best_d   <= n_best_d;
        r_found    <= n_found;
        r_mval     <= n_mval;
        r_lo       <= n_lo;
        r_sub      <= n_sub;
        r_has_b    <= n_has_b;
        r_out_pos  <= n_out_pos;
        r_out_vtx  <= n_out_vtx;
        r_out_dist <= n_out_dist;
        r_out_last <= n_out_last;
    end

    // Sequencer: next state, cell control, store access and result loading.
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_d         = r_d;
        n_best_d    = r_best_d;
        n_found     = r_found;
        n_mval      = r_mval;
        n_lo        = r_lo;
        n_sub       = r_sub;
        n_has_b     = r_has_b;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_vtx   = r_out_vtx;
        n_out_dist  = r_out_dist;
        n_out_last  = r_out_last;

        w_ctl         = '0;
        w_ctl.n       = r_n;
        w_ctl.lo      = r_lo;
        w_ctl.mval    = r_mval;
        w_ctl.la_data = w_rdata_a;
        w_ctl.lb_data = w_rdata_b;

        w_we      = 1'b0;
        w_waddr   = bfshp_pkg::edge_addr(bfshp_pkg::t_vidx'(i_cmd.vertex_a),
                                         bfshp_pkg::t_vidx'(i_cmd.vertex_b));
        w_wdata   = bfshp_pkg::t_weight'(i_cmd.weight);
        w_raddr_a = bfshp_pkg::edge_addr(r_k - bfshp_pkg::t_vidx'(1), r_k);
        w_raddr_b = w_raddr_a;

        unique case (r_state)
            bfshp_pkg::ST_IDLE: begin
                if (w_cmd_fire) begin
                    if (i_cmd.cmd == bfshp_pkg::CMD_WRITE_EDGE) begin
                        w_we = w_edge_ok;
                    end else begin
                        w_ctl.init = 1'b1;
                        n_n        = w_n_clamped;
                        n_k        = bfshp_pkg::t_vidx'(1);
                        n_d        = '0;
                        n_state    = bfshp_pkg::ST_INIT_RD;
                    end
                end
            end
            bfshp_pkg::ST_INIT_RD: begin
                // Read the link between positions k-1 and k of the identity order.
                n_state = bfshp_pkg::ST_INIT_ACC;
            end
            bfshp_pkg::ST_INIT_ACC: begin
                w_ctl.la_we  = 1'b1;
                w_ctl.la_pos = r_k;
                n_d          = w_d_init;
                if (bfshp_pkg::t_cnt'(r_k) + bfshp_pkg::t_cnt'(1) == r_n) begin
                    // The first order is always the best so far.
                    n_best_d      = w_d_init;
                    w_ctl.capture = 1'b1;
                    n_found       = w_found;
                    n_mval        = w_mval;
                    n_lo          = w_lo;
                    n_state       = bfshp_pkg::ST_SWAP;
                end else begin
                    n_k     = r_k + bfshp_pkg::t_vidx'(1);
                    n_state = bfshp_pkg::ST_INIT_RD;
                end
            end
            bfshp_pkg::ST_SWAP: begin
                if (!r_found) begin
                    // Listing is complete: present the first vertex of the best path.
                    n_k         = '0;
                    n_out_valid = 1'b1;
                    n_out_pos   = '0;
                    n_out_vtx   = bfshp_pkg::t_vfield'(w_stat[0].best);
                    n_out_dist  = bfshp_pkg::sat_dist(r_best_d);
                    n_out_last  = 1'b0;
                    n_state     = bfshp_pkg::ST_OUT;
                end else begin
                    // Swap positions lo and lo+1, read the new links at lo and, if still on the path, lo+2.
                    w_ctl.swap = 1'b1;
                    w_raddr_a  = bfshp_pkg::edge_addr(w_stat[r_lo - bfshp_pkg::t_vidx'(1)].val,
                                                      w_stat[r_lo + bfshp_pkg::t_vidx'(1)].val);
                    w_raddr_b  = bfshp_pkg::edge_addr(w_stat[r_lo].val, w_stat[w_lo2].val);
                    n_has_b    = w_has_b;
                    n_sub      = bfshp_pkg::t_sum'(w_stat[r_lo].link)
                                 + (w_has_b ? bfshp_pkg::t_sum'(w_stat[w_lo2].link) : '0);
                    n_state    = bfshp_pkg::ST_UPD;
                end
            end
            bfshp_pkg::ST_UPD: begin
                w_ctl.la_we  = 1'b1;
                w_ctl.la_pos = r_lo;
                w_ctl.lb_we  = r_has_b;
                w_ctl.lb_pos = r_lo + bfshp_pkg::t_vidx'(2);
                n_d          = w_d_new;
                if (w_d_new < r_best_d) begin
                    n_best_d      = w_d_new;
                    w_ctl.capture = 1'b1;
                end
                // The cells already hold the new order: pick the next move now.
                n_found = w_found;
                n_mval  = w_mval;
                n_lo    = w_lo;
                n_state = bfshp_pkg::ST_SWAP;
            end
            bfshp_pkg::ST_OUT: begin
                if (w_res_fire) begin
                    if (r_out_last) begin
                        n_out_valid = 1'b0;
                        n_state     = bfshp_pkg::ST_IDLE;
                    end else begin
                        n_k        = r_k + bfshp_pkg::t_vidx'(1);
                        n_out_pos  = bfshp_pkg::t_vfield'(n_k);
                        n_out_vtx  = bfshp_pkg::t_vfield'(w_stat[n_k].best);
                        n_out_last = (bfshp_pkg::t_cnt'(n_k) + bfshp_pkg::t_cnt'(1) == r_n);
                    end
                end
            end
            default: begin
                n_state = bfshp_pkg::ST_IDLE;
            end
        endcase
    end

    // Channel outputs.
    assign i_cmd.ready          = (r_state == bfshp_pkg::ST_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.position       = r_out_pos;
    assign o_res.vertex         = r_out_vtx;
    assign o_res.total_distance = r_out_dist;
    assign o_res.last           = r_out_last;

endmodule

// ----- sim/bfshp_path_checker.sv -----
// Checker for the shortest Hamiltonian path core: watches the command, result and APB ports.
// Keeps its own weight store and register copy, predicts each search and compares results.
// Depends on bfshp_pkg and the channel interfaces in bfshp_if.
module bfshp_path_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bfshp_cmd_if                         i_cmd_mon,
    bfshp_res_if                         i_res_mon,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [bfshp_pkg::APB_AW-1:0] i_paddr,
    input  logic [bfshp_pkg::APB_DW-1:0] i_pwdata,
    input  logic [bfshp_pkg::APB_DW-1:0] i_prdata,
    input  logic                         i_pready,
    output int                           o_fail_count,
    output int                           o_pending
);

    // Byte address of the vertex_count register.
    localparam logic [bfshp_pkg::APB_AW-1:0] REG_ADDR =
        bfshp_pkg::APB_AW'(4 * int'(bfshp_pkg::REG_VERTEX_COUNT));

    // One expected vertex of the best path.
    typedef struct packed {
        bfshp_pkg::t_vfield position;
        bfshp_pkg::t_vfield vertex;
        bfshp_pkg::t_dist   total_distance;
        logic               last;
    } t_path_step;

    bfshp_pkg::t_weight edge_wt [bfshp_pkg::MAX_VERTICES][bfshp_pkg::MAX_VERTICES];
    bfshp_pkg::t_vfield best_path [bfshp_pkg::MAX_VERTICES];
    int                 best_total;
    bfshp_pkg::t_vfield vertex_count;
    t_path_step         expected_path [$];
    int                 errors;

    assign o_fail_count = errors;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        errors++;
    endtask

    // Walk all orders of vertices 1..n-1 behind vertex 0 by adjacent swaps and keep
    // the first order whose path weight is strictly below the best so far.
    function automatic void find_shortest_path(input int n);
        bfshp_pkg::t_vfield order [bfshp_pkg::MAX_VERTICES];
        logic               to_right [bfshp_pkg::MAX_VERTICES];
        logic               have_best;
        logic               done;
        logic               ok;
        logic               tf;
        bfshp_pkg::t_vfield mval;
        bfshp_pkg::t_vfield moved;
        bfshp_pkg::t_vfield tv;
        int                 sum;
        int                 mob;
        int                 j;
        for (int i = 0; i < bfshp_pkg::MAX_VERTICES; i++) begin
            order[i]    = bfshp_pkg::t_vfield'(i);
            to_right[i] = 1'b0;
        end
        have_best  = 1'b0;
        done       = 1'b0;
        best_total = bfshp_pkg::DIST_MAX;
        while (!done) begin
            sum = 0;
            for (int i = 1; i < n; i++) begin
                sum += int'(edge_wt[order[i-1]][order[i]]);
            end
            if (!have_best || sum < best_total) begin
                have_best  = 1'b1;
                best_total = sum;
                best_path  = order;
            end
            // Largest element that points at a smaller neighbor; position 0 is fixed.
            mob  = 0;
            mval = '0;
            for (int i = 1; i < n; i++) begin
                if (!to_right[i]) begin
                    ok = (i >= 2) && (order[i] > order[i-1]);
                end else begin
                    ok = (i + 1 < n) && (order[i] > order[i+1]);
                end
                if (ok && order[i] > mval) begin
                    mob  = i;
                    mval = order[i];
                end
            end
            if (mob == 0) begin
                done = 1'b1;
            end else begin
                j = to_right[mob] ? mob + 1 : mob - 1;
                tv = order[mob];    order[mob]    = order[j];    order[j]    = tv;
                tf = to_right[mob]; to_right[mob] = to_right[j]; to_right[j] = tf;
                moved = order[j];
                for (int i = 1; i < n; i++) begin
                    if (order[i] > moved) begin
                        to_right[i] = !to_right[i];
                    end
                end
            end
        end
    endfunction

    // Track the register and weight store, predict searches and check results.
    always @(posedge i_clk) begin
        t_path_step       step;
        t_path_step       seen;
        int               n;
        bfshp_pkg::t_dist sat_total;
        if (!i_rst_n) begin
            for (int a = 0; a < bfshp_pkg::MAX_VERTICES; a++) begin
                for (int b = 0; b < bfshp_pkg::MAX_VERTICES; b++) begin
                    edge_wt[a][b] = '0;
                end
            end
            vertex_count = bfshp_pkg::t_vfield'(bfshp_pkg::VCOUNT_RESET);
            expected_path.delete();
        end else begin
            // Register writes and read-back.
            if (i_psel && i_penable && i_pready && i_paddr == REG_ADDR) begin
                if (i_pwrite) begin
                    vertex_count = i_pwdata[bfshp_pkg::VFIELD_W-1:0];
                end else if (i_prdata !== bfshp_pkg::APB_DW'(vertex_count)) begin
                    report_mismatch($sformatf("vertex_count read %0d, expected %0d",
                                              i_prdata, vertex_count));
                end
            end

            // Command transactions update the store or start a predicted search.
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                if (i_cmd_mon.cmd == bfshp_pkg::CMD_WRITE_EDGE) begin
                    if ((i_cmd_mon.vertex_a < bfshp_pkg::MAX_VERTICES)
                        && (i_cmd_mon.vertex_b < bfshp_pkg::MAX_VERTICES)) begin
                        edge_wt[i_cmd_mon.vertex_a][i_cmd_mon.vertex_b] =
                            bfshp_pkg::t_weight'(i_cmd_mon.weight);
                        edge_wt[i_cmd_mon.vertex_b][i_cmd_mon.vertex_a] =
                            bfshp_pkg::t_weight'(i_cmd_mon.weight);
                    end
                end else begin
                    n = int'(vertex_count);
                    if (n < bfshp_pkg::MIN_VERTICES) n = bfshp_pkg::MIN_VERTICES;
                    if (n > bfshp_pkg::MAX_VERTICES) n = bfshp_pkg::MAX_VERTICES;
                    find_shortest_path(n);
                    sat_total = (best_total > bfshp_pkg::DIST_MAX)
                                ? bfshp_pkg::t_dist'(bfshp_pkg::DIST_MAX)
                                : bfshp_pkg::t_dist'(best_total);
                    for (int k = 0; k < n; k++) begin
                        step.position       = bfshp_pkg::t_vfield'(k);
                        step.vertex         = best_path[k];
                        step.total_distance = sat_total;
                        step.last           = (k + 1 == n);
                        expected_path       = {expected_path, step};
                    end
                end
            end

            // Result transactions against the oldest expectation.
            if (i_res_mon.valid && i_res_mon.ready) begin
                seen.position       = i_res_mon.position;
                seen.vertex         = i_res_mon.vertex;
                seen.total_distance = i_res_mon.total_distance;
                seen.last           = i_res_mon.last;
                if (expected_path.size() == 0) begin
                    report_mismatch($sformatf("unexpected result position %0d vertex %0d",
                                              seen.position, seen.vertex));
                end else begin
                    step = expected_path.pop_front();
                    if (seen.position !== step.position)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  seen.position, step.position));
                    if (seen.vertex !== step.vertex)
                        report_mismatch($sformatf("vertex %0d at position %0d, expected %0d",
                                                  seen.vertex, step.position, step.vertex));
                    if (seen.total_distance !== step.total_distance)
                        report_mismatch($sformatf("total_distance %0d, expected %0d",
                                                  seen.total_distance, step.total_distance));
                    if (seen.last !== step.last)
                        report_mismatch($sformatf("last %0b at position %0d, expected %0b",
                                                  seen.last, step.position, step.last));
                end
            end
        end
        o_pending <= expected_path.size();
    end

endmodule

// ----- sim/brute_force_shortest_hamiltonian_path_core_tb.sv -----
// Top of the testbench for the shortest Hamiltonian path core: clock, reset, stimulus, verdict.
// Drives edge writes, searches and vertex_count settings; bfshp_path_checker does the checking.
// Depends on bfshp_pkg, bfshp_if, the core and sim/bfshp_path_checker.sv.
module brute_force_shortest_hamiltonian_path_core_tb;

    localparam logic [bfshp_pkg::APB_AW-1:0] VCOUNT_ADDR =
        bfshp_pkg::APB_AW'(4 * int'(bfshp_pkg::REG_VERTEX_COUNT));
    localparam int TOTAL_ITEMS    = 100;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 40;
    // Slowest search used here is nine vertices, during which nothing is accepted.
    localparam int WATCHDOG_LIMIT = 400000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [bfshp_pkg::APB_AW-1:0] paddr;
    logic [bfshp_pkg::APB_DW-1:0] pwdata;
    logic [bfshp_pkg::APB_DW-1:0] prdata;
    logic                         pready;
    int                           fail_count;
    int                           pending;
    int                           stall_cycles;
    int                           items_sent;
    bit                           cmd_steady;
    bit                           res_steady;

    bfshp_cmd_if cmd_ch ();
    bfshp_res_if res_ch ();

    brute_force_shortest_hamiltonian_path_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bfshp_path_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_res_mon    (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls before each transaction.
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 11) == 0) res_steady = !res_steady;
            gap = res_steady ? 0 : $urandom_range(0, 3);
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_ch.valid && res_ch.ready)) @(posedge i_clk);
        end
    end

    // One command transaction, after a random gap.
    task automatic send_cmd(input logic cmd, input bfshp_pkg::t_vfield a,
                            input bfshp_pkg::t_vfield b, input bfshp_pkg::t_wfield w);
        int gap;
        if ($urandom_range(0, 11) == 0) cmd_steady = !cmd_steady;
        gap = cmd_steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.cmd      <= cmd;
        cmd_ch.vertex_a <= a;
        cmd_ch.vertex_b <= b;
        cmd_ch.weight   <= w;
        cmd_ch.valid    <= 1'b1;
        @(posedge i_clk);
        while (!(cmd_ch.valid && cmd_ch.ready)) @(posedge i_clk);
        items_sent++;
    endtask

    // A search carries junk in its other fields.
    task automatic send_search();
        send_cmd(bfshp_pkg::CMD_SEARCH, bfshp_pkg::t_vfield'($urandom),
                 bfshp_pkg::t_vfield'($urandom), bfshp_pkg::t_wfield'($urandom));
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_idle(input int extra);
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_xfer(input logic wr, input logic [bfshp_pkg::APB_AW-1:0] addr,
                            input logic [bfshp_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change vertex_count only while the core is idle; optionally read it back.
    task automatic configure(input int vcount, input bit read_back);
        wait_idle(SETTLE_CYCLES);
        apb_xfer(1'b1, VCOUNT_ADDR, bfshp_pkg::APB_DW'(vcount));
        if (read_back) begin
            @(posedge i_clk);
            apb_xfer(1'b0, VCOUNT_ADDR, '0);
        end
    endtask

    initial begin
        int vcount;
        int n;
        int nwrites;
        int wmax;
        int top_v;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.cmd      <= bfshp_pkg::CMD_WRITE_EDGE;
        cmd_ch.vertex_a <= '0;
        cmd_ch.vertex_b <= '0;
        cmd_ch.weight   <= '0;
        stall_cycles    = 0;
        items_sent      = 0;
        cmd_steady      = 1'b0;
        res_steady      = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset value, all-zero store, clamping of vertex_count,
        // ignored and diagonal writes, and one nine-vertex search.
        apb_xfer(1'b0, VCOUNT_ADDR, '0);
        configure(0, 1'b1);
        send_search();
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd0, 4'd1, 8'd255);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd1, 4'd2, 8'd255);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd2, 4'd0, 8'd1);
        send_search();
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd2, 4'd2, 8'hAA);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd12, 4'd0, 8'd7);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd0, 4'd15, 8'd9);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd15, 4'd15, 8'd255);
        send_search();
        configure(15, 1'b1);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd11, 4'd10, 8'h81);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd10, 4'd11, 8'h7E);
        configure(2, 1'b1);
        send_search();
        configure(9, 1'b0);
        for (int i = 0; i < 5; i++) begin
            send_cmd(bfshp_pkg::CMD_WRITE_EDGE, bfshp_pkg::t_vfield'($urandom_range(0, 8)),
                     bfshp_pkg::t_vfield'($urandom_range(0, 8)),
                     bfshp_pkg::t_wfield'($urandom));
        end
        send_search();
        configure(12, 1'b1);
        send_cmd(bfshp_pkg::CMD_WRITE_EDGE, 4'd11, 4'd11, 8'd0);

        // Random part: phases of one setting, a batch of edge writes, then searches of up to eight vertices.
        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1:   vcount = $urandom_range(0, 2);
                16, 17: vcount = 8;
                18, 19: vcount = $urandom_range(9, 15);
                default: vcount = $urandom_range(3, 7);
            endcase
            configure(vcount, 1'($urandom_range(0, 1)));
            n = (vcount < bfshp_pkg::MIN_VERTICES) ? bfshp_pkg::MIN_VERTICES : vcount;
            if (n > bfshp_pkg::MAX_VERTICES) n = bfshp_pkg::MAX_VERTICES;
            // Small weights make equal path totals common.
            wmax    = ($urandom_range(0, 2) == 0) ? 3 : 255;
            top_v   = ($urandom_range(0, 3) == 0) ? bfshp_pkg::MAX_VERTICES - 1 : n - 1;
            nwrites = $urandom_range(1, 8);
            for (int i = 0; i < nwrites; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_cmd(bfshp_pkg::CMD_WRITE_EDGE, bfshp_pkg::t_vfield'($urandom),
                             bfshp_pkg::t_vfield'($urandom), bfshp_pkg::t_wfield'($urandom));
                end else begin
                    send_cmd(bfshp_pkg::CMD_WRITE_EDGE,
                             bfshp_pkg::t_vfield'($urandom_range(0, top_v)),
                             bfshp_pkg::t_vfield'($urandom_range(0, top_v)),
                             bfshp_pkg::t_wfield'($urandom_range(0, wmax)));
                end
            end
            // Searches beyond eight vertices take too long to repeat.
            if (n <= 8) begin
                repeat ($urandom_range(1, 2)) send_search();
            end
        end

        // Drain and verdict.
        wait_idle(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
